@@ src/dprem_pkg.sv @@
`default_nettype none

package dprem_pkg;

  // Shared memory geometry
  localparam int MemBytes = 4096;
  localparam int MemAw    = $clog2(MemBytes);
  localparam int PageW    = 4;
  localparam int WinW     = MemAw - PageW;

  // Console-side special addresses
  localparam logic [MemAw-1:0] ConMboxWrAddr = 12'hff0;
  localparam logic [MemAw-1:0] ConStatusAddr = 12'hff1;
  localparam logic [MemAw-1:0] ConMboxRdAddr = 12'hff2;

  // Control register bit positions
  localparam int CtrlOwnBit = 4;

  // Status byte bit positions
  localparam int StatIdleBit = 7;
  localparam int StatPendBit = 6;

  // Bus command codes
  typedef enum logic [3:0] {
    CmdHostStatusRd = 4'd0,
    CmdHostMboxRd   = 4'd1,
    CmdCtrlWr       = 4'd2,
    CmdHostMboxWr   = 4'd3,
    CmdWinRd        = 4'd4,
    CmdWinWr        = 4'd5,
    CmdConRd        = 4'd6,
    CmdConWr        = 4'd7,
    CmdFlagReset    = 4'd8
  } cmd_e;

  // One bus transaction
  typedef struct packed {
    logic [3:0]       cmd;
    logic [MemAw-1:0] addr;
    logic [7:0]       data_in;
  } in_t;

  // One result
  typedef struct packed {
    logic [7:0] read_data;
    logic       to_console_pending;
    logic       to_host_pending;
  } out_t;

  // Memory access request from the register block
  typedef struct packed {
    logic             we;
    logic             re;
    logic [MemAw-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  // Result before the output register; use_mem picks the memory read data
  typedef struct packed {
    logic [7:0] read_data;
    logic       use_mem;
    logic       to_console_pending;
    logic       to_host_pending;
  } res_t;

endpackage

`default_nettype wire

@@ src/dprem_mem.sv @@
`default_nettype none

module dprem_mem (
  input  wire                                 clk_i,
  input  dprem_pkg::mem_req_t                 req_i,
  output logic [7:0]                          rdata_o
);

  logic [7:0] mem_q [dprem_pkg::MemBytes];
  logic [7:0] rdata_q;

  // Single port: write and registered read, both enabled per transaction
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/dprem_regs.sv @@
`default_nettype none

module dprem_regs (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   fire_i,
  input  dprem_pkg::in_t        item_i,
  output dprem_pkg::mem_req_t   mem_req_o,
  output dprem_pkg::res_t       res_o
);

  logic                         owns_q, owns_d;
  logic [dprem_pkg::PageW-1:0]  page_q, page_d;
  logic [7:0]                   m2c_q, m2c_d;
  logic [7:0]                   m2h_q, m2h_d;
  logic                         cflag_q, cflag_d;
  logic                         hflag_q, hflag_d;
  logic                         we_c, re_c;
  logic [dprem_pkg::MemAw-1:0]  maddr_c;
  logic [7:0]                   rd_c;

  // Command decode and next state
  always_comb begin
    owns_d  = owns_q;
    page_d  = page_q;
    m2c_d   = m2c_q;
    m2h_d   = m2h_q;
    cflag_d = cflag_q;
    hflag_d = hflag_q;
    we_c    = 1'b0;
    re_c    = 1'b0;
    rd_c    = 8'h00;
    maddr_c = {page_q, item_i.addr[dprem_pkg::WinW-1:0]};
    unique case (dprem_pkg::cmd_e'(item_i.cmd))
      dprem_pkg::CmdHostStatusRd: begin
        rd_c[dprem_pkg::StatIdleBit] = ~cflag_q;
        rd_c[dprem_pkg::StatPendBit] = hflag_q;
      end
      dprem_pkg::CmdHostMboxRd: begin
        rd_c    = m2h_q;
        hflag_d = 1'b0;
      end
      dprem_pkg::CmdCtrlWr: begin
        owns_d = item_i.data_in[dprem_pkg::CtrlOwnBit];
        page_d = item_i.data_in[dprem_pkg::PageW-1:0];
      end
      dprem_pkg::CmdHostMboxWr: begin
        m2c_d   = item_i.data_in;
        cflag_d = 1'b1;
      end
      dprem_pkg::CmdWinRd: begin
        re_c = ~owns_q;
      end
      dprem_pkg::CmdWinWr: begin
        we_c = ~owns_q;
      end
      dprem_pkg::CmdConRd: begin
        maddr_c = item_i.addr;
        priority if (item_i.addr == dprem_pkg::ConStatusAddr) begin
          rd_c[dprem_pkg::StatIdleBit] = ~hflag_q;
          rd_c[dprem_pkg::StatPendBit] = cflag_q;
        end else if (item_i.addr == dprem_pkg::ConMboxRdAddr) begin
          rd_c    = m2c_q;
          cflag_d = 1'b0;
        end else begin
          re_c = owns_q;
        end
      end
      dprem_pkg::CmdConWr: begin
        if (item_i.addr == dprem_pkg::ConMboxWrAddr) begin
          m2h_d   = item_i.data_in;
          hflag_d = 1'b1;
        end
      end
      dprem_pkg::CmdFlagReset: begin
        cflag_d = 1'b0;
        hflag_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control and mailbox state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owns_q  <= 1'b0;
      page_q  <= '0;
      m2c_q   <= 8'h00;
      m2h_q   <= 8'h00;
      cflag_q <= 1'b0;
      hflag_q <= 1'b0;
    end else if (fire_i) begin
      owns_q  <= owns_d;
      page_q  <= page_d;
      m2c_q   <= m2c_d;
      m2h_q   <= m2h_d;
      cflag_q <= cflag_d;
      hflag_q <= hflag_d;
    end
  end

  assign mem_req_o.we    = we_c & fire_i;
  assign mem_req_o.re    = re_c & fire_i;
  assign mem_req_o.addr  = maddr_c;
  assign mem_req_o.wdata = item_i.data_in;

  // Flags reported are those after this transaction
  assign res_o.read_data          = rd_c;
  assign res_o.use_mem            = re_c;
  assign res_o.to_console_pending = cflag_d;
  assign res_o.to_host_pending    = hflag_d;

endmodule

`default_nettype wire

@@ src/dual_port_rom_emulator_mailbox.sv @@
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | in_data_i  (cmd, addr, data_in)
// out     | output    | out_valid_o/out_stall_i | out_data_o (read_data, pending flags)
//
// One transaction per cycle sustained while out_stall_i is low; a transaction passes the input register,
// then the result register together with the registered memory read port.
// Reset clears the pipeline valids, ownership, page, mailboxes and flags;
// the shared memory is not cleared and needs no clearing pass.
// in_stall_o rises in the same cycle when both stages hold a transaction
// and out_stall_i is high.
`default_nettype none

module dual_port_rom_emulator_mailbox (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  dprem_pkg::in_t      in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output dprem_pkg::out_t     out_data_o
);

  logic                 a_valid_q;
  dprem_pkg::in_t       a_item_q;
  logic                 b_valid_q;
  dprem_pkg::res_t      b_res_q;
  logic                 b_stall;
  logic                 a_fire;
  logic                 in_fire;
  dprem_pkg::mem_req_t  mem_req;
  dprem_pkg::res_t      res;
  logic [7:0]           mem_rdata;

  // Pipeline handshake
  assign b_stall    = b_valid_q & out_stall_i;
  assign a_fire     = a_valid_q & ~b_stall;
  assign in_stall_o = a_valid_q & b_stall;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= in_data_i;
    end
  end

  dprem_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (a_fire),
    .item_i    (a_item_q),
    .mem_req_o (mem_req),
    .res_o     (res)
  );

  dprem_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_stall) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_res_q <= res;
    end
  end

  assign out_valid_o                   = b_valid_q;
  assign out_data_o.read_data          = b_res_q.use_mem ? mem_rdata : b_res_q.read_data;
  assign out_data_o.to_console_pending = b_res_q.to_console_pending;
  assign out_data_o.to_host_pending    = b_res_q.to_host_pending;

endmodule

`default_nettype wire

@@ src/dprem_checker.sv @@
`default_nettype none

module dprem_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_stall_o,
  input dprem_pkg::in_t  in_data_i,
  input wire             out_valid_o,
  input wire             out_stall_i,
  input dprem_pkg::out_t out_data_o
);

  // A stalled transaction stays offered with the same payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while stalled");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Input back-pressure only comes from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A new result follows a transaction accepted through the input register and the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching transaction");

endmodule

bind dual_port_rom_emulator_mailbox dprem_checker u_dprem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
